@@ design/lrrp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the leaky relu requantize packer
// no dependencies; used by every module of the block

package lrrp_pkg;

  localparam int unsigned AccWidth      = 32;
  localparam int unsigned HalfWidth     = 16;
  localparam int unsigned WordWidth     = 2 * HalfWidth;
  localparam int unsigned LeakMulWidth  = 13;
  localparam int unsigned ProdWidth     = AccWidth + LeakMulWidth;
  localparam int unsigned LeakShift     = 15;
  localparam int unsigned LeakMul       = 32'h0000_0ccc;
  localparam int unsigned ShiftWidth    = 5;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = ShiftWidth;

  // queue between front and back; depth must be a power of two
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth = QueuePtrWidth + 1;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgLeakyEnable = 2'd0,
    CfgConvMode    = 2'd1,
    CfgOutputShift = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic                  leaky_enable;
    logic                  conv_mode;
    logic [ShiftWidth-1:0] output_shift;
  } cfg_t;

  typedef struct packed {
    logic [HalfWidth-1:0] half;
    logic                 last;
  } queue_entry_t;

endpackage

@@ design/lrrp_front.sv @@
`timescale 1ns / 1ps
// front part: accepts accumulator values, applies leaky slope and output shift
// depends on lrrp_pkg; feeds lrrp_queue

module lrrp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lrrp_pkg::cfg_t                     cfg_i,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic [lrrp_pkg::AccWidth-1:0]      s_data_i,
  input  logic                               s_last_i,
  output logic                               push_valid_o,
  output lrrp_pkg::queue_entry_t             push_entry_o,
  input  logic                               push_ready_i
);

  logic [lrrp_pkg::ProdWidth-1:0] prod;
  logic [lrrp_pkg::AccWidth-1:0]  leaked;
  logic [lrrp_pkg::AccWidth-1:0]  s1_value_d, s1_value_q;
  logic                           s1_last_q;
  logic                           s1_valid_q;
  logic                           load;
  logic [lrrp_pkg::ShiftWidth-1:0] amount;
  logic signed [lrrp_pkg::AccWidth-1:0] s1_signed;
  logic signed [lrrp_pkg::AccWidth-1:0] shifted;

  // modular product of the sign-extended operands, exact within ProdWidth
  assign prod = {{lrrp_pkg::LeakMulWidth{s_data_i[lrrp_pkg::AccWidth-1]}}, s_data_i}
              * lrrp_pkg::ProdWidth'(lrrp_pkg::LeakMul);
  // floor of product / 2^15 always fits back into the accumulator width
  assign leaked = {
    {(lrrp_pkg::AccWidth + lrrp_pkg::LeakShift - lrrp_pkg::ProdWidth)
      {prod[lrrp_pkg::ProdWidth-1]}},
    prod[lrrp_pkg::ProdWidth-1:lrrp_pkg::LeakShift]
  };

  always_comb begin
    if (cfg_i.leaky_enable && s_data_i[lrrp_pkg::AccWidth-1]) begin
      s1_value_d = leaked;
    end else begin
      s1_value_d = s_data_i;
    end
  end

  assign s_ready_o = !s1_valid_q || push_ready_i;
  assign load      = s_valid_i && s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_ready_o) begin
      s1_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_value_q <= s1_value_d;
      s1_last_q  <= s_last_i;
    end
  end

  assign amount    = cfg_i.conv_mode ? cfg_i.output_shift : '0;
  assign s1_signed = s1_value_q;
  assign shifted   = s1_signed >>> amount;

  assign push_valid_o      = s1_valid_q;
  assign push_entry_o.half = shifted[lrrp_pkg::HalfWidth-1:0];
  assign push_entry_o.last = s1_last_q;

endmodule

@@ design/lrrp_queue.sv @@
`timescale 1ns / 1ps
// short queue of requantized halves between front and back
// depends on lrrp_pkg

module lrrp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  input  lrrp_pkg::queue_entry_t push_entry_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output lrrp_pkg::queue_entry_t pop_entry_o,
  input  logic                   pop_ready_i
);

  lrrp_pkg::queue_entry_t               entries_q [lrrp_pkg::QueueDepth];
  logic [lrrp_pkg::QueuePtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lrrp_pkg::QueueCntWidth-1:0]   count_q, count_d;
  logic                                 push, pop;

  assign push_ready_o = count_q != lrrp_pkg::QueueCntWidth'(lrrp_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lrrp_pkg::QueueCntWidth'(lrrp_pkg::QueueDepth))
    else $error("queue fill count beyond depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q == rd_ptr_q + count_q[lrrp_pkg::QueuePtrWidth-1:0])
    else $error("queue pointers and fill count disagree");
`endif

endmodule

@@ design/lrrp_back.sv @@
`timescale 1ns / 1ps
// back part: pairs requantized halves into words and flushes odd leftovers
// depends on lrrp_pkg; drains lrrp_queue

module lrrp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  input  lrrp_pkg::queue_entry_t            pop_entry_i,
  output logic                              pop_ready_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [lrrp_pkg::WordWidth-1:0]    m_data_o,
  output logic                              m_last_o
);

  logic [lrrp_pkg::HalfWidth-1:0] held_q, held_d;
  logic                           pending_q, pending_d;
  logic                           out_valid_q, out_valid_d;
  logic [lrrp_pkg::WordWidth-1:0] out_data_q, out_data_d;
  logic                           out_last_q, out_last_d;
  logic                           pop, emit;

  assign pop_ready_o = !out_valid_q || m_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign emit        = pop && (pending_q || pop_entry_i.last);

  always_comb begin
    held_d      = held_q;
    pending_d   = pending_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_ready_i;
    if (pop) begin
      priority if (pending_q) begin
        out_data_d = {pop_entry_i.half, held_q};
        out_last_d = pop_entry_i.last;
        pending_d  = 1'b0;
        held_d     = '0;
      end else if (pop_entry_i.last) begin
        // odd leftover at row end, high half zero
        out_data_d = {{lrrp_pkg::HalfWidth{1'b0}}, pop_entry_i.half};
        out_last_d = 1'b1;
      end else begin
        held_d    = pop_entry_i.half;
        pending_d = 1'b1;
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

`ifndef ASSERT_OFF
  a_held_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q |-> held_q == '0)
    else $error("held half not cleared while nothing pending");

  a_row_end_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && pop_entry_i.last |=> !pending_q && out_valid_q && out_last_q)
    else $error("row end left a half pending or no final word");

  a_word_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop))
    else $error("output word appeared without a queue transfer");
`endif

endmodule

@@ design/leaky_relu_requantize_packer_core.sv @@
`timescale 1ns / 1ps
// Accepts one signed 32-bit accumulator value per cycle, with no gaps needed
// between transfers. Each value passes a registered multiply stage (leaky slope
// 0xccc/32768 on negatives if enabled), then in conv mode an arithmetic output
// shift, into a four-entry queue; the packer behind it emits one 32-bit word per
// pair, earlier value in bits 15:0, or a word with a zero high half for an odd
// value at row end, registered at the output. The sustained rate is one value
// per cycle, held off only when the output side stalls long enough to fill the
// queue. Configuration writes are taken at any time and must only be issued
// while the block is empty.
// depends on lrrp_pkg, lrrp_front, lrrp_queue, lrrp_back

module leaky_relu_requantize_packer_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lrrp_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [lrrp_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [lrrp_pkg::AccWidth-1:0]         s_axis_tdata,  // [31:0] acc_value
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [lrrp_pkg::WordWidth-1:0]        m_axis_tdata,  // [31:0] packed_word
  output logic                                  m_axis_tlast
);

  lrrp_pkg::cfg_t         cfg_q;
  lrrp_pkg::queue_entry_t push_entry, pop_entry;
  logic                   push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leaky_enable <= 1'b1;
      cfg_q.conv_mode    <= 1'b1;
      cfg_q.output_shift <= '0;
    end else if (cfg_valid_i) begin
      unique case (lrrp_pkg::cfg_index_e'(cfg_index_i))
        lrrp_pkg::CfgLeakyEnable: cfg_q.leaky_enable <= cfg_data_i[0];
        lrrp_pkg::CfgConvMode:    cfg_q.conv_mode    <= cfg_data_i[0];
        lrrp_pkg::CfgOutputShift: cfg_q.output_shift <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  lrrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  lrrp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  lrrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

@@ tb/leaky_relu_requantize_packer_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of leaky_relu_requantize_packer_core: streams accumulator
// values, writes the config registers between phases and predicts every packed word
// depends on lrrp_pkg and leaky_relu_requantize_packer_core

module leaky_relu_requantize_packer_core_tb;
  import lrrp_pkg::*;

  localparam int unsigned RandItems    = 900;
  localparam int unsigned TailItems    = 120;
  localparam int unsigned SettleCycles = 8;
  localparam logic [CfgIndexWidth-1:0] CfgUnused = 2'd3;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [AccWidth-1:0]      value;
    logic                     last;
    logic [CfgIndexWidth-1:0] index;
    logic                     typed;
    logic [WordWidth-1:0]     word;
    logic                     word_last;
  } plan_row_t;

  typedef struct {
    logic [WordWidth-1:0] word;
    logic                 last;
  } due_word_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i   = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [AccWidth-1:0]      s_axis_tdata  = '0;  // [31:0] acc_value
  logic                     s_axis_tlast  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [WordWidth-1:0]     m_axis_tdata;        // [31:0] packed_word
  logic                     m_axis_tlast;

  // predicted copy of the block's settings and packing state
  logic                  cfg_leaky = 1'b1;
  logic                  cfg_conv  = 1'b1;
  logic [ShiftWidth-1:0] cfg_shift = '0;
  logic [HalfWidth-1:0]  held_half = '0;
  logic                  half_held = 1'b0;

  due_word_t   words_due[$];
  int unsigned mismatches  = 0;
  int unsigned values_sent = 0;
  int unsigned sink_left   = 0;
  bit          quiet       = 1'b0;

  leaky_relu_requantize_packer_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** leaky_relu_requantize_packer_core: FAILED **");
    $finish;
  end

  function automatic logic [HalfWidth-1:0] requantize_half(input logic [AccWidth-1:0] acc);
    logic signed [ProdWidth-1:0] prod;
    logic signed [ProdWidth-1:0] slope;
    logic signed [AccWidth-1:0]  v;
    slope = LeakMul;
    v     = acc;
    if (cfg_leaky && v[AccWidth-1]) begin
      prod = v;
      prod = (prod * slope) >>> LeakShift;
      v    = prod[AccWidth-1:0];
    end
    if (cfg_conv) begin
      v = v >>> cfg_shift;
    end
    return v[HalfWidth-1:0];
  endfunction

  function automatic plan_row_t item_row(input logic [AccWidth-1:0] value, input logic last,
                                         input logic typed, input logic [WordWidth-1:0] word,
                                         input logic word_last);
    return '{RowItem, value, last, '0, typed, word, word_last};
  endfunction

  function automatic plan_row_t cfg_row(input logic [CfgIndexWidth-1:0] index,
                                        input logic [CfgDataWidth-1:0] data);
    return '{RowCfg, AccWidth'(data), 1'b0, index, 1'b0, '0, 1'b0};
  endfunction

  function automatic logic [AccWidth-1:0] pick_acc();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return '1;
          default: return '0;
        endcase
      end
      // values near the 16-bit range, both signs
      1, 2:    return AccWidth'($urandom_range(0, 140000) - 70000);
      default: return AccWidth'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // steps the packing state; a typed word replaces the predicted one
  task automatic pack_expect(input logic [AccWidth-1:0] acc, input logic last,
                             input logic typed, input logic [WordWidth-1:0] tword,
                             input logic tlast);
    logic [HalfWidth-1:0] half;
    due_word_t            due;
    logic                 emit;
    half = requantize_half(acc);
    emit = 1'b1;
    if (half_held) begin
      due.word  = {half, held_half};
      due.last  = last;
      half_held = 1'b0;
      held_half = '0;
    end else if (last) begin
      due.word = {{HalfWidth{1'b0}}, half};
      due.last = 1'b1;
    end else begin
      held_half = half;
      half_held = 1'b1;
      emit      = 1'b0;
    end
    if (emit) begin
      if (typed) begin
        due.word = tword;
        due.last = tlast;
      end
      words_due.push_back(due);
    end
  endtask

  task automatic send_acc(input logic [AccWidth-1:0] acc, input logic last,
                          input logic typed, input logic [WordWidth-1:0] tword,
                          input logic tlast);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= acc;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pack_expect(acc, last, typed, tword, tlast);
    values_sent++;
  endtask

  // waits until the block has drained before touching a register
  task automatic write_reg(input logic [CfgIndexWidth-1:0] index,
                           input logic [CfgDataWidth-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CfgLeakyEnable: cfg_leaky = data[0];
      CfgConvMode:    cfg_conv  = data[0];
      CfgOutputShift: cfg_shift = data[ShiftWidth-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : sink
    if (sink_left == 0) begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        sink_left = $urandom_range(1, 40);
      end else begin
        m_axis_tready <= 1'b0;
        sink_left = $urandom_range(1, 17);
      end
    end
    sink_left--;
  end

  always @(posedge clk_i) begin : monitor
    due_word_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (words_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        due = words_due.pop_front();
        if (m_axis_tdata !== due.word) begin
          flag_mismatch($sformatf("packed_word %h, predicted %h", m_axis_tdata, due.word));
        end
        if (m_axis_tlast !== due.last) begin
          flag_mismatch($sformatf("word_last %b, predicted %b", m_axis_tlast, due.last));
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t             plan[$];
    int unsigned           rand_base;
    int unsigned           rows;
    int unsigned           len;
    logic [CfgDataWidth-1:0] shift_pick;

    // reset settings: leaky on, conv on, no shift
    plan.push_back(item_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1));
    plan.push_back(item_row(32'h7fff_ffff, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'h0000_0001, 1'b1, 1'b1, 32'h0001_ffff, 1'b1));
    plan.push_back(item_row(32'hffff_ffff, 1'b1, 1'b1, 32'h0000_ffff, 1'b1));
    // pair closes mid row, then odd leftover whose value wraps
    plan.push_back(item_row(32'h8000_0000, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'h1234_5678, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'h0001_0005, 1'b1, 1'b1, 32'h0000_0005, 1'b1));
    plan.push_back(cfg_row(CfgLeakyEnable, 5'd0));
    plan.push_back(item_row(32'h8000_0000, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'hffff_8000, 1'b1, 1'b1, 32'h8000_0000, 1'b1));
    plan.push_back(cfg_row(CfgOutputShift, 5'd31));
    plan.push_back(item_row(32'h7fff_ffff, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'h8000_0000, 1'b1, 1'b1, 32'hffff_0000, 1'b1));
    plan.push_back(cfg_row(CfgOutputShift, 5'd16));
    plan.push_back(item_row(32'h1234_5678, 1'b1, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'hdead_beef, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'h0000_0000, 1'b1, 1'b0, '0, 1'b0));
    plan.push_back(cfg_row(CfgLeakyEnable, 5'd1));
    plan.push_back(item_row(32'h8000_0000, 1'b1, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'hfff0_0000, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'h0123_4567, 1'b1, 1'b0, '0, 1'b0));
    plan.push_back(cfg_row(CfgConvMode, 5'd0));
    plan.push_back(item_row(32'habcd_1234, 1'b0, 1'b0, '0, 1'b0));
    plan.push_back(item_row(32'h0000_5678, 1'b1, 1'b0, '0, 1'b0));
    // write to the unused index must leave conv mode off
    plan.push_back(cfg_row(CfgUnused, 5'd31));
    plan.push_back(item_row(32'h0000_0010, 1'b1, 1'b1, 32'h0000_0010, 1'b1));
    plan.push_back(cfg_row(CfgConvMode, 5'd1));
    plan.push_back(item_row(32'h4000_0000, 1'b1, 1'b0, '0, 1'b0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) begin
        write_reg(plan[i].index, plan[i].value[CfgDataWidth-1:0]);
      end else begin
        send_acc(plan[i].value, plan[i].last, plan[i].typed, plan[i].word,
                 plan[i].word_last);
      end
    end

    // random phases: fresh settings, then whole rows so nothing is held across a write
    rand_base = values_sent;
    while (values_sent - rand_base < RandItems) begin
      write_reg(CfgLeakyEnable, CfgDataWidth'($urandom));
      write_reg(CfgConvMode, CfgDataWidth'($urandom));
      case ($urandom_range(0, 3))
        0:       shift_pick = '0;
        1:       shift_pick = '1;
        default: shift_pick = CfgDataWidth'($urandom_range(0, 31));
      endcase
      write_reg(CfgOutputShift, shift_pick);
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CfgUnused, CfgDataWidth'($urandom));
      end
      rows = $urandom_range(2, 8);
      repeat (rows) begin
        len = $urandom_range(1, 9);
        for (int unsigned k = 0; k < len; k++) begin
          quiet = (values_sent - rand_base) >= (RandItems - TailItems);
          send_acc(pick_acc(), k == len - 1, 1'b0, '0, 1'b0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** leaky_relu_requantize_packer_core: PASSED **");
    end else begin
      $display("** leaky_relu_requantize_packer_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lrrp_pkg.sv
design/lrrp_front.sv
design/lrrp_queue.sv
design/lrrp_back.sv
design/leaky_relu_requantize_packer_core.sv
tb/leaky_relu_requantize_packer_core_tb.sv
